// ===== sv/swmt_pkg.sv =====
// Shared constants, register codes and stage flag type of the multiplicity trigger.
package swmt_pkg;

  localparam int CFG_ADDR_BITS = 1;
  localparam int CFG_DATA_BITS = 32;
  localparam int COUNT_BITS    = 16;
  localparam int WINDOW_BITS   = 32;

  localparam logic [COUNT_BITS-1:0]  COUNT_NEEDED_RST = 16'd54794;
  localparam logic [WINDOW_BITS-1:0] WINDOW_TICKS_RST = 32'd51200;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_COUNT_NEEDED = 1'b0,
    CFG_WINDOW_TICKS = 1'b1
  } cfg_reg_t;

  // Per-hit control passed from the ring-address stage to the event tracker.
  typedef struct packed {
    logic last;   // final hit of the event
    logic first;  // hit index zero
    logic cand;   // hit may fire: not saturated, spacing fits, enough hits seen
    logic same;   // spacing zero, compare the hit with itself
  } swmt_flags_t;

endpackage

// ===== sv/swmt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module swmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/swmt_ingest.sv =====
// Hit counter, ring pointers and the stage register feeding the event tracker.
module swmt_ingest import swmt_pkg::*; #(
  parameter int RING_DEPTH = 65536,
  parameter int INDEX_BITS = 24,
  parameter int TIME_BITS  = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [TIME_BITS-1:0]          hit_time,
  input  logic                          last_hit,
  input  logic [COUNT_BITS-1:0]         count_needed,
  input  logic                          s1_go,
  output logic                          s1_valid,
  output swmt_flags_t                   s1_flags,
  output logic [TIME_BITS-1:0]          s1_time,
  output logic [INDEX_BITS-1:0]         s1_index,
  output logic [INDEX_BITS-1:0]         s1_count,
  output logic                          ring_we,
  output logic [$clog2(RING_DEPTH)-1:0] ring_waddr,
  output logic [$clog2(RING_DEPTH)-1:0] ring_raddr
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = ((AW > COUNT_BITS) ? AW : COUNT_BITS) + 1;
  localparam int KW = (INDEX_BITS > COUNT_BITS) ? INDEX_BITS : COUNT_BITS;

  logic [INDEX_BITS-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic                  s1_valid_r, s1_valid_nxt;
  swmt_flags_t           s1_flags_r, flags_nxt;
  logic [TIME_BITS-1:0]  s1_time_r;
  logic [INDEX_BITS-1:0] s1_index_r;
  logic [INDEX_BITS-1:0] s1_count_r, count_after;
  logic                  sat;
  logic [CW-1:0]         ptr_ext, need_ext, back_addr;

  assign sat      = (cnt_r == {INDEX_BITS{1'b1}});
  assign ptr_ext  = CW'(ptr_r);
  assign need_ext = CW'(count_needed);

  // Ring slot of hit k - N, wrapped into the ring.
  always_comb begin
    if (ptr_ext >= need_ext) begin
      back_addr = ptr_ext - need_ext;
    end else begin
      back_addr = ptr_ext + CW'(RING_DEPTH) - need_ext;
    end
  end

  assign count_after = sat ? cnt_r : cnt_r + 1'b1;

  always_comb begin
    flags_nxt.last  = last_hit;
    flags_nxt.first = (cnt_r == '0);
    flags_nxt.same  = (count_needed == '0);
    flags_nxt.cand  = !sat && (32'(count_needed) < 32'(RING_DEPTH)) &&
                      (KW'(cnt_r) >= KW'(count_needed));
  end

  always_comb begin
    cnt_nxt = cnt_r;
    ptr_nxt = ptr_r;
    if (accept) begin
      if (last_hit) begin
        cnt_nxt = '0;
        ptr_nxt = '0;
      end else if (!sat) begin
        cnt_nxt = cnt_r + 1'b1;
        ptr_nxt = (ptr_r == AW'(RING_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
      end
    end
  end

  assign s1_valid_nxt = accept | (s1_valid_r & ~s1_go);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      ptr_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      ptr_r      <= ptr_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags_r <= flags_nxt;
      s1_time_r  <= hit_time;
      s1_index_r <= cnt_r;
      s1_count_r <= count_after;
    end
  end

  assign ring_we    = accept & ~sat;
  assign ring_waddr = ptr_r;
  assign ring_raddr = back_addr[AW-1:0];

  assign s1_valid = s1_valid_r;
  assign s1_flags = s1_flags_r;
  assign s1_time  = s1_time_r;
  assign s1_index = s1_index_r;
  assign s1_count = s1_count_r;

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last_hit |=> cnt_r == '0 && ptr_r == '0)
    else $error("hit counter not cleared after final hit");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ptr_r) < 32'(RING_DEPTH))
    else $error("ring pointer out of range");

endmodule

// ===== sv/swmt_track.sv =====
// Event tracker: window compare on ring data, tail search and result register.
module swmt_track import swmt_pkg::*; #(
  parameter int INDEX_BITS = 24,
  parameter int TIME_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  s1_valid,
  input  swmt_flags_t           s1_flags,
  input  logic [TIME_BITS-1:0]  s1_time,
  input  logic [INDEX_BITS-1:0] s1_index,
  input  logic [INDEX_BITS-1:0] s1_count,
  input  logic [TIME_BITS-1:0]  ring_rdata,
  input  logic [COUNT_BITS-1:0] count_needed,
  input  logic [TIME_BITS-1:0]  window,
  input  logic                  out_stall,
  output logic                  s1_go,
  output logic                  out_valid,
  output logic                  out_found,
  output logic [INDEX_BITS-1:0] out_start_index,
  output logic [INDEX_BITS-1:0] out_trigger_index,
  output logic [INDEX_BITS-1:0] out_end_index,
  output logic [TIME_BITS-1:0]  out_trigger_delay
);

  localparam int KW = (INDEX_BITS > COUNT_BITS) ? INDEX_BITS : COUNT_BITS;

  logic                  fired_r, fired_nxt;
  logic                  tail_found_r, tail_found_nxt;
  logic [TIME_BITS-1:0]  first_time_r, first_time_nxt;
  logic [INDEX_BITS-1:0] fire_index_r, fire_index_nxt;
  logic [TIME_BITS-1:0]  fire_time_r, fire_time_nxt;
  logic [TIME_BITS:0]    fire_limit_r, fire_limit_nxt;
  logic [INDEX_BITS-1:0] tail_index_r, tail_index_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r;
  logic [INDEX_BITS-1:0] out_start_r, out_trigger_r, out_end_r;
  logic [TIME_BITS-1:0]  out_delay_r;

  logic [TIME_BITS-1:0]  past;
  logic [TIME_BITS:0]    sum;
  logic                  fire_now, tail_now, found, load;
  logic [KW-1:0]         start_diff;
  logic [TIME_BITS-1:0]  delay;

  assign s1_go = s1_valid & ~(s1_flags.last & out_valid_r & out_stall);
  assign load  = s1_go & s1_flags.last;

  assign past     = s1_flags.same ? s1_time : ring_rdata;
  assign sum      = {1'b0, s1_time} + {1'b0, window};
  assign fire_now = s1_flags.cand && !fired_r &&
                    ({1'b0, s1_time} < ({1'b0, past} + {1'b0, window}));
  // The tail hit is looked for only after a hit that fired earlier.
  assign tail_now = fired_r && !tail_found_r && ({1'b0, s1_time} > fire_limit_r);
  assign found    = fired_r | fire_now;

  always_comb begin
    first_time_nxt = s1_flags.first ? s1_time : first_time_r;
    fire_index_nxt = fire_now ? s1_index : fire_index_r;
    fire_time_nxt  = fire_now ? s1_time : fire_time_r;
    fire_limit_nxt = fire_now ? sum : fire_limit_r;
    tail_index_nxt = tail_now ? s1_index : tail_index_r;
    tail_found_nxt = tail_found_r | tail_now;
    fired_nxt      = found;
    if (s1_flags.last) begin
      fired_nxt      = 1'b0;
      tail_found_nxt = 1'b0;
    end
  end

  assign start_diff = KW'(fire_index_nxt) - KW'(count_needed);
  assign delay      = fire_time_nxt - first_time_nxt;

  assign out_valid_nxt = load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fired_r      <= 1'b0;
      tail_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (s1_go) begin
        fired_r      <= fired_nxt;
        tail_found_r <= tail_found_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      first_time_r <= first_time_nxt;
      fire_index_r <= fire_index_nxt;
      fire_time_r  <= fire_time_nxt;
      fire_limit_r <= fire_limit_nxt;
      tail_index_r <= tail_index_nxt;
    end
    if (load) begin
      out_found_r   <= found;
      out_start_r   <= found ? start_diff[INDEX_BITS-1:0] : '0;
      out_trigger_r <= found ? fire_index_nxt : '0;
      out_end_r     <= (tail_found_r | tail_now) ? tail_index_nxt : s1_count;
      out_delay_r   <= found ? delay : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_start_index   = out_start_r;
  assign out_trigger_index = out_trigger_r;
  assign out_end_index     = out_end_r;
  assign out_trigger_delay = out_delay_r;

  a_tail_after_fire: assert property (@(posedge clk) disable iff (!rst_n)
    !fired_r |-> !tail_found_r)
    else $error("tail hit recorded without a trigger");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && s1_flags.last && out_valid_r && out_stall |-> !s1_go)
    else $error("final hit advanced over a waiting result");

endmodule

// ===== sv/sliding_window_multiplicity_trigger_unit.sv =====
// Top level of the sliding-window multiplicity trigger.
// Takes one hit per cycle while in_stall is low, time-sorted within an event,
// and fires at the first hit k (k >= count_needed) whose time lies less than
// window_ticks after hit k - count_needed; recent hit times live in a
// RING_DEPTH-entry ring memory written and read on transfer, whose registered
// read data meets the hit in the stage register for the window compare. The
// event state and, for a final hit, the output register are loaded as the hit
// leaves the stage register; in_stall rises only while a final hit waits for
// a stalled, still occupied output register. Ring entries need no clearing
// pass after reset: only entries written earlier in the same event are used.
// Change configuration only while no event is in progress.
module sliding_window_multiplicity_trigger_unit import swmt_pkg::*; #(
  parameter int RING_DEPTH = 65536,
  parameter int INDEX_BITS = 24,
  parameter int TIME_BITS  = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [TIME_BITS-1:0]     in_hit_time,
  input  logic                     in_last_hit,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_found,
  output logic [INDEX_BITS-1:0]    out_start_index,
  output logic [INDEX_BITS-1:0]    out_trigger_index,
  output logic [INDEX_BITS-1:0]    out_end_index,
  output logic [TIME_BITS-1:0]     out_trigger_delay
);

  localparam int AW = $clog2(RING_DEPTH);

  logic [COUNT_BITS-1:0]  count_needed_r;
  logic [WINDOW_BITS-1:0] window_ticks_r;
  logic [63:0]            window_ext;
  logic [TIME_BITS-1:0]   window;

  logic                  accept;
  logic                  s1_go, s1_valid;
  swmt_flags_t           s1_flags;
  logic [TIME_BITS-1:0]  s1_time, ring_rdata;
  logic [INDEX_BITS-1:0] s1_index, s1_count;
  logic                  ring_we;
  logic [AW-1:0]         ring_waddr, ring_raddr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_needed_r <= COUNT_NEEDED_RST;
      window_ticks_r <= WINDOW_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COUNT_NEEDED: count_needed_r <= cfg_wdata[COUNT_BITS-1:0];
        CFG_WINDOW_TICKS: window_ticks_r <= cfg_wdata[WINDOW_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign window_ext = {32'b0, window_ticks_r};
  assign window     = window_ext[TIME_BITS-1:0];

  assign in_stall = s1_valid & ~s1_go;
  assign accept   = in_valid & ~in_stall;

  swmt_ingest #(
    .RING_DEPTH (RING_DEPTH),
    .INDEX_BITS (INDEX_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_ingest (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .hit_time     (in_hit_time),
    .last_hit     (in_last_hit),
    .count_needed (count_needed_r),
    .s1_go        (s1_go),
    .s1_valid     (s1_valid),
    .s1_flags     (s1_flags),
    .s1_time      (s1_time),
    .s1_index     (s1_index),
    .s1_count     (s1_count),
    .ring_we      (ring_we),
    .ring_waddr   (ring_waddr),
    .ring_raddr   (ring_raddr)
  );

  swmt_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (in_hit_time),
    .re    (accept),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  swmt_track #(
    .INDEX_BITS (INDEX_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_track (
    .clk               (clk),
    .rst_n             (rst_n),
    .s1_valid          (s1_valid),
    .s1_flags          (s1_flags),
    .s1_time           (s1_time),
    .s1_index          (s1_index),
    .s1_count          (s1_count),
    .ring_rdata        (ring_rdata),
    .count_needed      (count_needed_r),
    .window            (window),
    .out_stall         (out_stall),
    .s1_go             (s1_go),
    .out_valid         (out_valid),
    .out_found         (out_found),
    .out_start_index   (out_start_index),
    .out_trigger_index (out_trigger_index),
    .out_end_index     (out_end_index),
    .out_trigger_delay (out_trigger_delay)
  );

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid && s1_flags.last && out_valid && out_stall)
    else $error("input stalled without a blocked final hit");

endmodule
